@@ hdl/priority_queue_sorted_store_macros.svh @@
// ---------------------------------------------------------------------------
// Priority queue sorted store: assertion macros
// Shared concurrent assertion forms for the block's RTL.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_SORTED_STORE_MACROS_SVH
`define PRIORITY_QUEUE_SORTED_STORE_MACROS_SVH

// Checks an implication on every rising edge outside reset.
`define PQSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define PQSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pqss_pkg.sv @@
// ---------------------------------------------------------------------------
// Priority queue sorted store: package
// Sizes, operation and status codes, entry types and ring addressing.
// ---------------------------------------------------------------------------
package pqss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         prio;
  } entry_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } wr_req_t;

  // Physical slot of a logical queue position, counted from the head.
  function automatic addr_t phys_addr(addr_t head, addr_t logical);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, logical};
    if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

@@ hdl/pqss_store.sv @@
// ---------------------------------------------------------------------------
// Priority queue sorted store: entry memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pqss_store (
  input  logic             clk,
  input  pqss_pkg::wr_req_t wr,
  input  pqss_pkg::addr_t  rd_addr,
  output pqss_pkg::entry_t rd_data
);
  import pqss_pkg::*;

  entry_t store_r [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_r[wr.addr] <= wr.data;
    end
    rd_data_r <= store_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/priority_queue_sorted_store.sv @@
// ---------------------------------------------------------------------------
// Priority queue sorted store
// Bounded priority queue of value and priority pairs kept in priority order.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. in_op selects insert,
// extract head or peek head; in_value and in_priority matter for insert only.
// Every item gives exactly one result, shown for one cycle with out_valid
// high; the receiver cannot stall it, so it must take it in that cycle.
// The entries live in a ring in a single-port-read memory, head first, so an
// extract only moves the head pointer. An insert walks from the tail towards
// the head, one entry at a time (a read in S_INS_RD, a compare and write in
// S_INS_CMP), moving each lower-priority entry up by one slot until the new
// entry's place is found. A full insert, an empty extract or peek, and an
// unused code are answered straight from idle. An extract or peek reads the
// head and answers from S_HEAD_OUT. An insert into an empty queue writes in
// S_INS_WR; any other insert stops by writing behind an entry of equal or
// higher priority in S_INS_CMP, or writes in S_INS_WR after moving every entry.
// The memory's one read port, stepped once per entry, sets the insert time.
// busy is high while an item is in progress.
// Synchronous reset empties the queue; memory contents are not cleared.
// ---------------------------------------------------------------------------
`include "priority_queue_sorted_store_macros.svh"

module priority_queue_sorted_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_value,
  input  logic [7:0]  in_priority,
  output logic        out_valid,
  output logic signed [31:0] out_value,
  output logic [7:0]  out_priority,
  output logic [1:0]  out_status
);
  import pqss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_HEAD_OUT
  } state_t;

  state_t     state_r;
  count_t     count_r;
  addr_t      head_r;
  addr_t      hole_r;
  logic [1:0] op_r;
  entry_t     new_r;

  logic              out_valid_r;
  logic signed [31:0] out_value_r;
  logic [7:0]        out_priority_r;
  logic [1:0]        out_status_r;

  wr_req_t wr;
  addr_t   rd_addr;
  entry_t  rd_data;

  pqss_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rd_addr = head_r;
    if (state_r == S_INS_RD) begin
      rd_addr = phys_addr(head_r, hole_r - addr_t'(1));
    end
    wr.en   = 1'b0;
    wr.addr = phys_addr(head_r, hole_r);
    wr.data = new_r;
    case (state_r)
      S_INS_CMP: begin
        wr.en = 1'b1;
        if (rd_data.prio < new_r.prio) begin
          wr.data = rd_data;
        end
      end
      S_INS_WR: begin
        wr.en = 1'b1;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r         <= in_op;
            new_r.value  <= in_value;
            new_r.prio   <= in_priority;
            out_value_r    <= '0;
            out_priority_r <= '0;
            case (in_op)
              OP_INSERT: begin
                if (count_r == count_t'(QUEUE_DEPTH)) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_FULL;
                end else begin
                  hole_r  <= count_r[ADDR_W-1:0];
                  state_r <= (count_r == '0) ? S_INS_WR : S_INS_RD;
                end
              end
              OP_EXTRACT, OP_PEEK: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_HEAD_OUT;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (rd_data.prio >= new_r.prio) begin
            count_r      <= count_r + count_t'(1);
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end else begin
            hole_r  <= hole_r - addr_t'(1);
            state_r <= (hole_r == addr_t'(1)) ? S_INS_WR : S_INS_RD;
          end
        end
        S_INS_WR: begin
          count_r      <= count_r + count_t'(1);
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          state_r      <= S_IDLE;
        end
        S_HEAD_OUT: begin
          out_valid_r    <= 1'b1;
          out_status_r   <= ST_OK;
          out_value_r    <= rd_data.value;
          out_priority_r <= rd_data.prio;
          if (op_r == OP_EXTRACT) begin
            count_r <= count_r - count_t'(1);
            head_r  <= (head_r == addr_t'(QUEUE_DEPTH - 1)) ? '0 : head_r + addr_t'(1);
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_priority = out_priority_r;
  assign out_status   = out_status_r;

  `PQSS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= count_t'(QUEUE_DEPTH), "Entry count exceeds depth.")
  `PQSS_ASSERT_IMP(a_result_idle, out_valid_r, state_r == S_IDLE, "Result shown while busy.")
  `PQSS_ASSERT_NEXT(a_accept_progress, start && !busy, out_valid_r || busy, "Item accepted but neither busy nor answered.")
  `PQSS_ASSERT_IMP(a_write_insert, wr.en, state_r == S_INS_CMP || state_r == S_INS_WR, "Memory written outside an insert.")
  `PQSS_ASSERT_IMP(a_full_insert, state_r == S_INS_RD || state_r == S_INS_WR, count_r != count_t'(QUEUE_DEPTH), "Insert running on a full queue.")

endmodule
